>>> hdl/atac_pkg.sv
// Shared widths, codes and the half-revolution wrap for the alt-az target unit.
`default_nettype none

package atac_pkg;

	localparam int UW  = 34;          // modulo reduction operand width (offset, always >= 0)
	localparam int RMW = 30;          // widest residue (one revolution is at most 2^30 counts)
	localparam int DPW = RMW + 1;     // wrapped difference, signed
	localparam int XW  = 33;          // axis target before limit checks, signed
	localparam int AW  = 27;          // angle in degrees Q.16, signed
	localparam int PW  = 60;          // angle times counts per degree, Q.32
	localparam int QW  = 28;          // integer part of that product

	localparam logic signed [AW-1:0] ANG_90_DEG = 27'sd5898240;

	typedef enum logic [1:0] {
		ZM_NONE = 2'd0,
		ZM_HALF = 2'd1,
		ZM_FULL = 2'd2
	} zmode_t;

	typedef enum logic [2:0] {
		CFG_AZ_ZERO_OFFSET   = 3'd0,
		CFG_ZD_ZERO_OFFSET   = 3'd1,
		CFG_AZ_COUNTS_PER_DEG  = 3'd2,
		CFG_ALT_COUNTS_PER_DEG = 3'd3,
		CFG_AZ_MIN_COUNTS    = 3'd4,
		CFG_AZ_MAX_COUNTS    = 3'd5,
		CFG_ALT_MIN_COUNTS   = 3'd6,
		CFG_ALT_MAX_COUNTS   = 3'd7
	} cfg_idx_t;

	// Residue r in [0, t) to the congruent value in [-t/2, t/2]; on an exact
	// half the sign follows pos.
	function automatic logic signed [DPW-1:0] wrap_half(input logic [RMW-1:0] r,
			input logic [RMW:0] t, input logic pos);
		logic [RMW+1:0] r2;
		logic [RMW+1:0] te;
		logic [RMW+1:0] diff;
		logic signed [DPW-1:0] res;
		r2   = {r, 1'b0};
		te   = {1'b0, t};
		diff = {2'b00, r} - te;
		if (r2 < te) begin
			res = $signed({1'b0, r});
		end else if (r2 > te) begin
			res = $signed(diff[DPW-1:0]);
		end else if (pos) begin
			res = $signed({1'b0, t[RMW:1]});
		end else begin
			res = -$signed({1'b0, t[RMW:1]});
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hdl/altaz_target_to_axis_counts_unit.sv
// Alt-az target to axis encoder counts: pipelined top level with configuration registers.
`default_nettype none

// A target altitude and azimuth (degrees, 16 fraction bits) is turned into
// encoder counts on both axes, moving by the shortest path from the present
// counts; azimuth is then normalised by zero_mode and brought inside the
// azimuth limits by whole revolutions. status is 1 when a limit is still
// broken, and the result then repeats the present counts. The unit is a
// plain pipeline: a transfer is taken whenever start is high (busy is
// always low), one per clock, and each result appears for exactly one cycle
// with done high, having passed stages s1 to s3, the reduction, s5 to s8
// and the result register. NSTG is the depth of the modulo reduction, at
// most one compare-subtract per stage: max over both axes of 35 - clog2(
// counts per revolution + 1), which is 10 for 2^24 counts per revolution.
// There is no back-pressure; the receiver must take every result.
// Configuration writes are registered and must only be made while no transfer is in flight.
module altaz_target_to_axis_counts_unit #(
	parameter int unsigned AZ_COUNTS_PER_REV  = 32'd16777216,
	parameter int unsigned ALT_COUNTS_PER_REV = 32'd16777216
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command side
	input  logic                     start,
	output logic                     busy,
	input  logic signed [31:0]       cur_az_counts,
	input  logic signed [31:0]       cur_alt_counts,
	input  logic [24:0]              target_az,
	input  logic signed [23:0]       target_alt,
	input  logic [1:0]               zero_mode,
	// result side
	output logic                     done,
	output logic signed [31:0]       new_az_counts,
	output logic signed [31:0]       new_alt_counts,
	output logic                     status,
	// configuration
	input  logic                     cfg_wr_en,
	input  atac_pkg::cfg_idx_t       cfg_index,
	input  logic [31:0]              cfg_data
);
	import atac_pkg::*;

	// ---------------------------------------------------------------------
	// Derived constants
	// ---------------------------------------------------------------------
	localparam int AZ_RW    = $clog2(AZ_COUNTS_PER_REV);
	localparam int ALT_RW   = $clog2(ALT_COUNTS_PER_REV);
	localparam int AZ_NEED  = UW + 1 - $clog2(AZ_COUNTS_PER_REV + 1);
	localparam int ALT_NEED = UW + 1 - $clog2(ALT_COUNTS_PER_REV + 1);
	localparam int NSTG     = (AZ_NEED > ALT_NEED) ? AZ_NEED : ALT_NEED;

	// Smallest whole number of revolutions at or above 2^32: added before reduction so
	// that every operand is positive without changing its residue.
	localparam logic [63:0] AZ_OFF64 = 64'(AZ_COUNTS_PER_REV) *
		((64'd4294967296 + 64'(AZ_COUNTS_PER_REV) - 64'd1) / 64'(AZ_COUNTS_PER_REV));
	localparam logic [63:0] ALT_OFF64 = 64'(ALT_COUNTS_PER_REV) *
		((64'd4294967296 + 64'(ALT_COUNTS_PER_REV) - 64'd1) / 64'(ALT_COUNTS_PER_REV));
	localparam logic [UW-1:0] AZ_OFF  = AZ_OFF64[UW-1:0];
	localparam logic [UW-1:0] ALT_OFF = ALT_OFF64[UW-1:0];

	localparam logic [RMW:0] AZ_T  = (RMW+1)'(AZ_COUNTS_PER_REV);
	localparam logic [RMW:0] ALT_T = (RMW+1)'(ALT_COUNTS_PER_REV);
	localparam logic signed [XW-1:0] AZ_REV  = $signed(XW'(AZ_T));
	localparam logic signed [XW-1:0] AZ_HALF = $signed(XW'(AZ_T[RMW:1]));

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic signed [25:0] az_zero_q;
	logic signed [25:0] zd_zero_q;
	logic [31:0]        az_cpd_q;
	logic [31:0]        alt_cpd_q;
	logic signed [31:0] az_min_q;
	logic signed [31:0] az_max_q;
	logic signed [31:0] alt_min_q;
	logic signed [31:0] alt_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_zero_q <= '0;
			zd_zero_q <= '0;
			az_cpd_q  <= 32'd65536;
			alt_cpd_q <= 32'd65536;
			az_min_q  <= -32'sd8388608;
			az_max_q  <= 32'sd8388608;
			alt_min_q <= -32'sd4194304;
			alt_max_q <= 32'sd4194304;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_AZ_ZERO_OFFSET:     az_zero_q <= $signed(cfg_data[25:0]);
				CFG_ZD_ZERO_OFFSET:     zd_zero_q <= $signed(cfg_data[25:0]);
				CFG_AZ_COUNTS_PER_DEG:  az_cpd_q  <= cfg_data;
				CFG_ALT_COUNTS_PER_DEG: alt_cpd_q <= cfg_data;
				CFG_AZ_MIN_COUNTS:      az_min_q  <= $signed(cfg_data);
				CFG_AZ_MAX_COUNTS:      az_max_q  <= $signed(cfg_data);
				CFG_ALT_MIN_COUNTS:     alt_min_q <= $signed(cfg_data);
				CFG_ALT_MAX_COUNTS:     alt_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// limits widened once for the wide comparisons downstream
	logic signed [UW-1:0] az_min_w;
	logic signed [UW-1:0] az_max_w;
	logic signed [XW-1:0] az_min_x;
	logic signed [XW-1:0] az_max_x;
	logic signed [XW-1:0] alt_min_x;
	logic signed [XW-1:0] alt_max_x;

	assign az_min_w  = $signed({{(UW-32){az_min_q[31]}}, az_min_q});
	assign az_max_w  = $signed({{(UW-32){az_max_q[31]}}, az_max_q});
	assign az_min_x  = $signed({az_min_q[31], az_min_q});
	assign az_max_x  = $signed({az_max_q[31], az_max_q});
	assign alt_min_x = $signed({alt_min_q[31], alt_min_q});
	assign alt_max_x = $signed({alt_max_q[31], alt_max_q});

	// A new transfer is taken every cycle.
	assign busy = 1'b0;

	// ---------------------------------------------------------------------
	// s1: register inputs, angles in degrees Q.16
	// ---------------------------------------------------------------------
	logic                 vld_s1;
	logic signed [31:0]   cur_az_s1;
	logic signed [31:0]   cur_alt_s1;
	logic [1:0]           mode_s1;
	logic signed [AW-1:0] az_ang_s1;
	logic signed [AW-1:0] zd_ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s1  <= cur_az_counts;
		cur_alt_s1 <= cur_alt_counts;
		mode_s1    <= zero_mode;
		az_ang_s1  <= $signed({2'b00, target_az}) - $signed({az_zero_q[25], az_zero_q});
		zd_ang_s1  <= ANG_90_DEG - $signed({{3{target_alt[23]}}, target_alt})
			- $signed({zd_zero_q[25], zd_zero_q});
	end

	// ---------------------------------------------------------------------
	// s2: angle times counts per degree (Q.32)
	// ---------------------------------------------------------------------
	logic                 vld_s2;
	logic signed [31:0]   cur_az_s2;
	logic signed [31:0]   cur_alt_s2;
	logic [1:0]           mode_s2;
	logic signed [PW-1:0] p_az_s2;
	logic signed [PW-1:0] p_alt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s2  <= cur_az_s1;
		cur_alt_s2 <= cur_alt_s1;
		mode_s2    <= mode_s1;
		p_az_s2    <= az_ang_s1 * $signed({1'b0, az_cpd_q});
		p_alt_s2   <= zd_ang_s1 * $signed({1'b0, alt_cpd_q});
	end

	// ---------------------------------------------------------------------
	// s3: floor of the product, plus the truncate-toward-zero correction.
	// cur - p/2^32 truncated is cur - floor - 1 when there is a fraction and
	// cur is above the floor.
	// ---------------------------------------------------------------------
	logic                 vld_s3;
	logic signed [31:0]   cur_az_s3;
	logic signed [31:0]   cur_alt_s3;
	logic [1:0]           mode_s3;
	logic signed [QW-1:0] q_az_s3;
	logic signed [QW-1:0] q_alt_s3;
	logic                 b_az_s3;
	logic                 b_alt_s3;

	logic signed [QW-1:0] q_az;
	logic signed [QW-1:0] q_alt;

	assign q_az  = p_az_s2[PW-1:32];
	assign q_alt = p_alt_s2[PW-1:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s3  <= cur_az_s2;
		cur_alt_s3 <= cur_alt_s2;
		mode_s3    <= mode_s2;
		q_az_s3    <= q_az;
		q_alt_s3   <= q_alt;
		b_az_s3    <= (|p_az_s2[31:0]) &&
			(cur_az_s2 > $signed({{(32-QW){q_az[QW-1]}}, q_az}));
		b_alt_s3   <= (|p_alt_s2[31:0]) &&
			(cur_alt_s2 > $signed({{(32-QW){q_alt[QW-1]}}, q_alt}));
	end

	// ---------------------------------------------------------------------
	// Reduction operands. d = cur - q - b is the count difference; the
	// pre-wrap azimuth target cur - d is just q + b, so its residue and the
	// residues against both limits are reduced in parallel with d.
	// ---------------------------------------------------------------------
	logic signed [UW-1:0] qb_az;
	logic signed [UW-1:0] qb_alt;
	logic signed [UW-1:0] d_az;
	logic signed [UW-1:0] d_alt;
	logic [UW-1:0]        u_d_az;
	logic [UW-1:0]        u_d_alt;
	logic [UW-1:0]        u_x;
	logic [UW-1:0]        u_min;
	logic [UW-1:0]        u_max;

	assign qb_az  = $signed({{(UW-QW){q_az_s3[QW-1]}}, q_az_s3}) + $signed(UW'(b_az_s3));
	assign qb_alt = $signed({{(UW-QW){q_alt_s3[QW-1]}}, q_alt_s3}) + $signed(UW'(b_alt_s3));
	assign d_az   = $signed({{(UW-32){cur_az_s3[31]}}, cur_az_s3}) - qb_az;
	assign d_alt  = $signed({{(UW-32){cur_alt_s3[31]}}, cur_alt_s3}) - qb_alt;

	// true sums are in [0, 2^UW), so wrapping arithmetic gives exact bits
	assign u_d_az  = unsigned'(d_az) + AZ_OFF;
	assign u_d_alt = unsigned'(d_alt) + ALT_OFF;
	assign u_x     = unsigned'(qb_az) + AZ_OFF;
	assign u_min   = unsigned'(qb_az - az_min_w) + AZ_OFF;
	assign u_max   = unsigned'(az_max_w - qb_az) + AZ_OFF;

	logic [AZ_RW-1:0]  r_d_az;
	logic [ALT_RW-1:0] r_d_alt;
	logic [AZ_RW-1:0]  r_x;
	logic [AZ_RW-1:0]  r_min;
	logic [AZ_RW-1:0]  r_max;

	atac_modred #(.T(AZ_COUNTS_PER_REV), .NSTG(NSTG)) u_red_d_az (
		.clk   (clk),
		.x_in  (u_d_az),
		.r_out (r_d_az)
	);

	atac_modred #(.T(ALT_COUNTS_PER_REV), .NSTG(NSTG)) u_red_d_alt (
		.clk   (clk),
		.x_in  (u_d_alt),
		.r_out (r_d_alt)
	);

	atac_modred #(.T(AZ_COUNTS_PER_REV), .NSTG(NSTG)) u_red_x (
		.clk   (clk),
		.x_in  (u_x),
		.r_out (r_x)
	);

	atac_modred #(.T(AZ_COUNTS_PER_REV), .NSTG(NSTG)) u_red_min (
		.clk   (clk),
		.x_in  (u_min),
		.r_out (r_min)
	);

	atac_modred #(.T(AZ_COUNTS_PER_REV), .NSTG(NSTG)) u_red_max (
		.clk   (clk),
		.x_in  (u_max),
		.r_out (r_max)
	);

	// sideband alongside the reduction stages
	typedef struct packed {
		logic signed [31:0] cur_az;
		logic signed [31:0] cur_alt;
		logic [1:0]         mode;
		logic               dpos_az;
		logic               dpos_alt;
	} side_t;

	side_t            side_in;
	side_t            side_q [NSTG];
	logic [NSTG-1:0]  vld_red_q;

	assign side_in.cur_az   = cur_az_s3;
	assign side_in.cur_alt  = cur_alt_s3;
	assign side_in.mode     = mode_s3;
	assign side_in.dpos_az  = !d_az[UW-1] && (d_az != '0);
	assign side_in.dpos_alt = !d_alt[UW-1] && (d_alt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_red_q <= '0;
		end else begin
			vld_red_q[0] <= vld_s3;
			for (int i = 1; i < NSTG; i++) begin
				vld_red_q[i] <= vld_red_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int i = 1; i < NSTG; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	side_t side_r;
	assign side_r = side_q[NSTG-1];

	// ---------------------------------------------------------------------
	// s5: shortest-path differences; azimuth residue prepared for the modes
	// ---------------------------------------------------------------------
	logic                  vld_s5;
	logic signed [31:0]    cur_az_s5;
	logic signed [31:0]    cur_alt_s5;
	logic [1:0]            mode_s5;
	logic signed [DPW-1:0] dw_az_s5;
	logic signed [DPW-1:0] dw_alt_s5;
	logic signed [DPW-1:0] xh_s5;      // residue wrapped, exact half taken as +T/2
	logic                  xtie_s5;    // residue is exactly half a revolution
	logic                  xzero_s5;
	logic [AZ_RW-1:0]      xr_s5;
	logic [AZ_RW-1:0]      rmin_s5;
	logic [AZ_RW-1:0]      rmax_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_red_q[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s5  <= side_r.cur_az;
		cur_alt_s5 <= side_r.cur_alt;
		mode_s5    <= side_r.mode;
		dw_az_s5   <= wrap_half(RMW'(r_d_az), AZ_T, side_r.dpos_az);
		dw_alt_s5  <= wrap_half(RMW'(r_d_alt), ALT_T, side_r.dpos_alt);
		xh_s5      <= wrap_half(RMW'(r_x), AZ_T, 1'b1);
		xtie_s5    <= ((RMW+1)'({r_x, 1'b0}) == AZ_T);
		xzero_s5   <= (r_x == '0);
		xr_s5      <= r_x;
		rmin_s5    <= r_min;
		rmax_s5    <= r_max;
	end

	// ---------------------------------------------------------------------
	// s6: axis targets before azimuth normalisation
	// ---------------------------------------------------------------------
	logic                  vld_s6;
	logic signed [31:0]    cur_az_s6;
	logic signed [31:0]    cur_alt_s6;
	logic [1:0]            mode_s6;
	logic signed [XW-1:0]  x_s6;
	logic signed [XW-1:0]  talt_s6;
	logic signed [DPW-1:0] xh_s6;
	logic                  xtie_s6;
	logic                  xzero_s6;
	logic [AZ_RW-1:0]      xr_s6;
	logic [AZ_RW-1:0]      rmin_s6;
	logic [AZ_RW-1:0]      rmax_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s6  <= cur_az_s5;
		cur_alt_s6 <= cur_alt_s5;
		mode_s6    <= mode_s5;
		x_s6       <= $signed({cur_az_s5[31], cur_az_s5}) - XW'(dw_az_s5);
		talt_s6    <= $signed({cur_alt_s5[31], cur_alt_s5}) - XW'(dw_alt_s5);
		xh_s6      <= xh_s5;
		xtie_s6    <= xtie_s5;
		xzero_s6   <= xzero_s5;
		xr_s6      <= xr_s5;
		rmin_s6    <= rmin_s5;
		rmax_s6    <= rmax_s5;
	end

	// ---------------------------------------------------------------------
	// s7: zero mode, then raise to the azimuth minimum; altitude limit check
	// ---------------------------------------------------------------------
	logic                 xpos;
	logic signed [XW-1:0] xm;
	logic signed [XW-1:0] x_raised;

	assign xpos = !x_s6[XW-1] && (x_s6 != '0);

	always_comb begin
		case (mode_s6)
			ZM_HALF: xm = (xtie_s6 && !xpos) ? -AZ_HALF : XW'(xh_s6);
			ZM_FULL: xm = (xzero_s6 && xpos) ? AZ_REV : $signed(XW'(xr_s6));
			ZM_NONE: xm = x_s6;
			default: xm = x_s6;
		endcase
	end

	// smallest value at or above the minimum with the same residue
	assign x_raised = (xm < az_min_x) ? (az_min_x + $signed(XW'(rmin_s6))) : xm;

	logic                 vld_s7;
	logic signed [31:0]   cur_az_s7;
	logic signed [31:0]   cur_alt_s7;
	logic signed [XW-1:0] x1_s7;
	logic signed [XW-1:0] talt_s7;
	logic                 alt_bad_s7;
	logic [AZ_RW-1:0]     rmax_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s7  <= cur_az_s6;
		cur_alt_s7 <= cur_alt_s6;
		x1_s7      <= x_raised;
		talt_s7    <= talt_s6;
		alt_bad_s7 <= (talt_s6 < alt_min_x) || (talt_s6 > alt_max_x);
		rmax_s7    <= rmax_s6;
	end

	// ---------------------------------------------------------------------
	// s8: lower to the azimuth maximum (largest value at or below it with
	// the same residue)
	// ---------------------------------------------------------------------
	logic                 vld_s8;
	logic signed [31:0]   cur_az_s8;
	logic signed [31:0]   cur_alt_s8;
	logic signed [XW-1:0] x2_s8;
	logic signed [XW-1:0] talt_s8;
	logic                 alt_bad_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		cur_az_s8  <= cur_az_s7;
		cur_alt_s8 <= cur_alt_s7;
		x2_s8      <= (x1_s7 > az_max_x) ? (az_max_x - $signed(XW'(rmax_s7))) : x1_s7;
		talt_s8    <= talt_s7;
		alt_bad_s8 <= alt_bad_s7;
	end

	// ---------------------------------------------------------------------
	// Result register: out of limits gives back the present counts
	// ---------------------------------------------------------------------
	logic               bad;
	logic               done_q;
	logic signed [31:0] new_az_q;
	logic signed [31:0] new_alt_q;
	logic               status_q;

	assign bad = alt_bad_s8 || (x2_s8 < az_min_x) || (x2_s8 > az_max_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		new_az_q  <= bad ? cur_az_s8 : $signed(x2_s8[31:0]);
		new_alt_q <= bad ? cur_alt_s8 : $signed(talt_s8[31:0]);
		status_q  <= bad;
	end

	assign done           = done_q;
	assign new_az_counts  = new_az_q;
	assign new_alt_counts = new_alt_q;
	assign status         = status_q;

endmodule

`default_nettype wire

>>> hdl/atac_modred.sv
// Pipelined modulo reduction by a fixed revolution, at most one compare-subtract per stage.
`default_nettype none

module atac_modred #(
	parameter int unsigned T    = 32'd16777216,
	parameter int          NSTG = 10
) (
	input  logic                      clk,
	input  logic [atac_pkg::UW-1:0]   x_in,
	output logic [$clog2(T)-1:0]      r_out
);
	import atac_pkg::*;

	// steps this modulus needs so that T << steps covers the whole operand
	localparam int NEED = UW + 1 - $clog2(T + 1);

	logic [UW-1:0] stg_q [NSTG];

	for (genvar i = 0; i < NSTG; i++) begin : g_step
		localparam int K = NSTG - 1 - i;
		logic [UW-1:0] x_cur;

		if (i == 0) begin : g_first
			assign x_cur = x_in;
		end else begin : g_next
			assign x_cur = stg_q[i-1];
		end

		if (K < NEED) begin : g_sub
			localparam logic [UW-1:0] TK = UW'(64'(T) << K);
			always_ff @(posedge clk) begin
				stg_q[i] <= (x_cur >= TK) ? (x_cur - TK) : x_cur;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				stg_q[i] <= x_cur;
			end
		end
	end

	assign r_out = stg_q[NSTG-1][$clog2(T)-1:0];

endmodule

`default_nettype wire
